/* src/tcc_pkg.sv */
package tcc_pkg;

    localparam int DEF_MAX_PATHS  = 16;
    localparam int DEF_COUNT_BITS = 32;

    localparam int FIRED_W     = 16;  // width of the fired-path mask
    localparam int ROW_W       = 4;   // width of a path index on the ports
    localparam int VALUE_W     = 32;  // width of count_value
    localparam int WIDE_W      = 64;  // width the merge widens a counter to
    localparam int NUM_PATHS_W = 5;

    localparam logic [NUM_PATHS_W-1:0] NUM_PATHS_RESET = 5'd16;

    typedef enum logic [0:0] {
        MODE_EVENT = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        KIND_EVENTS  = 2'd0,
        KIND_ACCEPTS = 2'd1,
        KIND_PATH    = 2'd2,
        KIND_PAIR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_READ
    } state_t;

    // write-back side of the pair-row sweep, shared by all lanes
    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             row_fired;  // path of this row fired
        logic             single;     // exactly one path fired
        logic             row_valid;  // row written since reset
    } sweep_ctl_t;

endpackage

/* src/tcc_lane.sv */
module tcc_lane #(
    parameter int LANES      = tcc_pkg::DEF_MAX_PATHS,
    parameter int COUNT_BITS = tcc_pkg::DEF_COUNT_BITS,
    parameter int LANE_IDX   = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      path_inc,
    input  logic                      fired_self,
    input  logic                      rd_en,
    input  logic [$clog2(LANES)-1:0]  rd_addr,
    input  tcc_pkg::sweep_ctl_t       sweep_ctl,
    output logic [COUNT_BITS-1:0]     pair_data,
    output logic [COUNT_BITS-1:0]     path_count
);
    import tcc_pkg::*;

    localparam int IDX_W = $clog2(LANES);

    // column LANE_IDX of the pair matrix, one entry per row
    logic [COUNT_BITS-1:0] mem [LANES];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] path_cnt_reg;
    logic [COUNT_BITS-1:0] path_cnt_next;
    logic [COUNT_BITS-1:0] old_val;
    logic [COUNT_BITS-1:0] new_val;
    logic                  pair_inc;
    logic                  on_diag;

    always_comb
    begin
        on_diag  = (sweep_ctl.wr_row == ROW_W'(LANE_IDX));
        pair_inc = sweep_ctl.row_fired &&
                   (sweep_ctl.single ? on_diag : (fired_self && !on_diag));
        old_val  = sweep_ctl.row_valid ? rd_data_reg : '0;
        new_val  = (pair_inc && !(&old_val)) ? old_val + COUNT_BITS'(1) : old_val;
        path_cnt_next = (path_inc && !(&path_cnt_reg)) ?
                        path_cnt_reg + COUNT_BITS'(1) : path_cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_ctl.wr_en)
        begin
            mem[sweep_ctl.wr_row[IDX_W-1:0]] <= new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_cnt_reg <= '0;
        end
        else
        begin
            path_cnt_reg <= path_cnt_next;
        end
    end

    assign pair_data  = rd_data_reg;
    assign path_count = path_cnt_reg;

endmodule

/* src/tcc_merge.sv */
module tcc_merge #(
    parameter int LANES      = tcc_pkg::DEF_MAX_PATHS,
    parameter int COUNT_BITS = tcc_pkg::DEF_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         is_read,
    input  tcc_pkg::kind_t               kind,
    input  logic [tcc_pkg::ROW_W-1:0]    row,
    input  logic [tcc_pkg::ROW_W-1:0]    col,
    input  logic                         row_valid,
    input  logic [COUNT_BITS-1:0]        pair_data [LANES],
    input  logic [COUNT_BITS-1:0]        path_data [LANES],
    input  logic [COUNT_BITS-1:0]        event_count,
    input  logic [COUNT_BITS-1:0]        accept_count,
    output logic [tcc_pkg::VALUE_W-1:0]  count_value
);
    import tcc_pkg::*;

    localparam int IDX_W = $clog2(LANES);

    logic [VALUE_W-1:0]    count_value_reg;
    logic [VALUE_W-1:0]    count_value_next;
    logic [COUNT_BITS-1:0] sel;
    logic [WIDE_W-1:0]     sel_wide;
    logic                  row_ok;
    logic                  col_ok;

    always_comb
    begin
        row_ok = ({1'b0, row} < (ROW_W + 1)'(LANES));
        col_ok = ({1'b0, col} < (ROW_W + 1)'(LANES));
        case (kind)
            KIND_EVENTS:  sel = event_count;
            KIND_ACCEPTS: sel = accept_count;
            KIND_PATH:    sel = row_ok ? path_data[row[IDX_W-1:0]] : '0;
            default:      sel = (row_ok && col_ok && row_valid) ?
                                pair_data[col[IDX_W-1:0]] : '0;
        endcase
        sel_wide         = WIDE_W'(sel);
        count_value_next = is_read ? sel_wide[VALUE_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_value_reg <= count_value_next;
        end
    end

    assign count_value = count_value_reg;

endmodule

/* src/trigger_coincidence_counter_core.sv */
// A read is busy in the READ state, then reports (done) from the done register.
//   An event with no counted path fired (or inactive / invalid / rejected) reports next cycle.
// Event with fired paths: busy in the SWEEP and FLUSH states, one pair row per cycle
//   through the lane memories' read and write ports, then done in the following cycle.
// Throughput: a transfer every cycle for unswept events; reads and sweeps block new ones while busy.
// Reset (rst_n, async, low) clears counters (pair rows via per-row valid bits); done lasts 1 cycle, no stall.
module trigger_coincidence_counter_core #(
    parameter int MAX_PATHS  = tcc_pkg::DEF_MAX_PATHS,
    parameter int COUNT_BITS = tcc_pkg::DEF_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic                              results_valid,
    input  logic                              global_accept,
    input  logic [tcc_pkg::FIRED_W-1:0]       fired_paths,
    input  logic [1:0]                        counter_kind,
    input  logic [tcc_pkg::ROW_W-1:0]         counter_row,
    input  logic [tcc_pkg::ROW_W-1:0]         counter_col,
    // result channel
    output logic                              done,
    output logic [tcc_pkg::VALUE_W-1:0]       count_value,
    output logic                              active,
    // num_paths register
    input  logic                              cfg_we,
    input  logic [tcc_pkg::NUM_PATHS_W-1:0]   cfg_data
);
    import tcc_pkg::*;

    // Only the low FIRED_W paths can ever fire, so lanes and rows stop there.
    localparam int LANES = (MAX_PATHS < FIRED_W) ? MAX_PATHS : FIRED_W;
    localparam int IDX_W = $clog2(LANES);

    state_t state_reg, state_next;

    logic [NUM_PATHS_W-1:0] num_paths_reg;
    logic                   stream_active_reg, stream_active_next;
    logic [COUNT_BITS-1:0]  event_count_reg, event_count_next;
    logic [COUNT_BITS-1:0]  accept_count_reg, accept_count_next;
    logic [LANES-1:0]       fired_reg, fired_next;
    logic                   single_reg, single_next;
    logic [IDX_W-1:0]       row_reg, row_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]       wr_row_reg;
    logic [LANES-1:0]       row_valid_reg, row_valid_next;
    logic                   done_reg, done_next;
    kind_t                  rd_kind_reg;
    logic [ROW_W-1:0]       rd_row_reg, rd_col_reg;

    logic                   accept;
    logic                   ev_counted;   // event transfer while the stream is active
    logic                   ev_accepted;  // ... with valid results and global accept
    logic [LANES-1:0]       mask;
    logic                   need_sweep;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   last_row;
    sweep_ctl_t             sweep_ctl;

    logic [COUNT_BITS-1:0]  pair_data [LANES];
    logic [COUNT_BITS-1:0]  path_data [LANES];

    assign accept   = start && !busy;
    assign last_row = (row_reg == IDX_W'(LANES - 1));

    // ---------------------------------------------------------------
    // Event decode: paths at or above num_paths are masked off here.
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mask[i] = fired_paths[i] && (NUM_PATHS_W'(i) < num_paths_reg);
        end
        ev_counted  = accept && (mode == MODE_EVENT) && stream_active_reg;
        ev_accepted = ev_counted && results_valid && global_accept;
        need_sweep  = ev_accepted && (|mask);
    end

    // ---------------------------------------------------------------
    // Scalar counters and the sticky active flag
    // ---------------------------------------------------------------
    always_comb
    begin
        stream_active_next = stream_active_reg;
        event_count_next   = event_count_reg;
        accept_count_next  = accept_count_reg;
        fired_next         = fired_reg;
        single_next        = single_reg;
        if (ev_counted)
        begin
            if (!(&event_count_reg))
            begin
                event_count_next = event_count_reg + COUNT_BITS'(1);
            end
            if (!results_valid)
            begin
                stream_active_next = 1'b0;
            end
        end
        if (ev_accepted)
        begin
            if (!(&accept_count_reg))
            begin
                accept_count_next = accept_count_reg + COUNT_BITS'(1);
            end
            fired_next  = mask;
            single_next = $onehot(mask);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_READ))
                begin
                    state_next = ST_READ;
                end
                else if (need_sweep)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (last_row)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: state_next = ST_IDLE;
            ST_READ:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs. Row r is read and then written back in the
    // next cycle, so consecutive rows never collide.
    // ---------------------------------------------------------------
    always_comb
    begin
        busy         = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = counter_row[IDX_W-1:0];
        row_next     = row_reg;
        wr_pend_next = 1'b0;
        done_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                if (accept && (mode == MODE_READ))
                begin
                    rd_en = 1'b1;
                end
                else if (accept && !need_sweep)
                begin
                    done_next = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                busy         = 1'b1;
                rd_en        = 1'b1;
                rd_addr      = row_reg;
                wr_pend_next = 1'b1;
                row_next     = last_row ? '0 : row_reg + IDX_W'(1);
            end
            ST_FLUSH:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            ST_READ:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        sweep_ctl.wr_en     = wr_pend_reg;
        sweep_ctl.wr_row    = ROW_W'(wr_row_reg);
        sweep_ctl.row_fired = fired_reg[wr_row_reg];
        sweep_ctl.single    = single_reg;
        sweep_ctl.row_valid = row_valid_reg[wr_row_reg];
        row_valid_next      = row_valid_reg;
        if (wr_pend_reg)
        begin
            row_valid_next[wr_row_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            num_paths_reg     <= NUM_PATHS_RESET;
            stream_active_reg <= 1'b1;
            event_count_reg   <= '0;
            accept_count_reg  <= '0;
            fired_reg         <= '0;
            single_reg        <= 1'b0;
            row_reg           <= '0;
            wr_pend_reg       <= 1'b0;
            row_valid_reg     <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            stream_active_reg <= stream_active_next;
            event_count_reg   <= event_count_next;
            accept_count_reg  <= accept_count_next;
            fired_reg         <= fired_next;
            single_reg        <= single_next;
            row_reg           <= row_next;
            wr_pend_reg       <= wr_pend_next;
            row_valid_reg     <= row_valid_next;
            done_reg          <= done_next;
            if (cfg_we)
            begin
                num_paths_reg <= cfg_data;
            end
        end
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        wr_row_reg <= row_reg;
        if (accept)
        begin
            rd_kind_reg <= kind_t'(counter_kind);
            rd_row_reg  <= counter_row;
            rd_col_reg  <= counter_col;
        end
    end

    // ---------------------------------------------------------------
    // One lane per pair-matrix column; lane j also owns path j's count.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        tcc_lane #(
            .LANES      (LANES),
            .COUNT_BITS (COUNT_BITS),
            .LANE_IDX   (j)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .path_inc   (ev_accepted && mask[j]),
            .fired_self (fired_reg[j]),
            .rd_en      (rd_en),
            .rd_addr    (rd_addr),
            .sweep_ctl  (sweep_ctl),
            .pair_data  (pair_data[j]),
            .path_count (path_data[j])
        );
    end

    tcc_merge #(
        .LANES      (LANES),
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .clk          (clk),
        .load         (done_next),
        .is_read      (state_reg == ST_READ),
        .kind         (rd_kind_reg),
        .row          (rd_row_reg),
        .col          (rd_col_reg),
        .row_valid    (row_valid_reg[rd_row_reg[IDX_W-1:0]]),
        .pair_data    (pair_data),
        .path_data    (path_data),
        .event_count  (event_count_reg),
        .accept_count (accept_count_reg),
        .count_value  (count_value)
    );

    // active reflects the item being reported: nothing else moves it before done
    assign done   = done_reg;
    assign active = stream_active_reg;

endmodule

/* src/tcc_checker.sv */
module tcc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             mode,
    input logic                             done,
    input logic                             active,
    input logic [tcc_pkg::VALUE_W-1:0]      count_value
);
    import tcc_pkg::*;

    // a read transfer always raises busy in the next cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_READ)) |=> busy)
        else $error("read transfer did not hold busy");

    // an event either reports at once or starts a sweep
    a_event_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_EVENT)) |=> (done || busy))
        else $error("event transfer produced neither result nor sweep");

    // the stream never reactivates without reset
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !active |=> !active)
        else $error("active flag rose again");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // an unswept event's result reports zero
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_EVENT)) ##1 done |-> (count_value == '0))
        else $error("nonzero count_value on event result");

endmodule

bind trigger_coincidence_counter_core tcc_checker u_tcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .done        (done),
    .active      (active),
    .count_value (count_value)
);

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // one command transfer as driven on the start channel
    typedef struct {
        mode_t                 op;
        logic                  results_valid;
        logic                  global_accept;
        logic [FIRED_W-1:0]    fired;
        kind_t                 kind;
        logic [ROW_W-1:0]      row;
        logic [ROW_W-1:0]      col;
    } command_t;

    // one result transfer as seen on the done strobe
    typedef struct {
        logic [VALUE_W-1:0]    count_value;
        logic                  active;
    } readout_t;

    localparam int PATHS = DEF_MAX_PATHS;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   mode = MODE_EVENT;
    logic                   results_valid = 1'b0;
    logic                   global_accept = 1'b0;
    logic [FIRED_W-1:0]     fired_paths = '0;
    logic [1:0]             counter_kind = KIND_EVENTS;
    logic [ROW_W-1:0]       counter_row = '0;
    logic [ROW_W-1:0]       counter_col = '0;
    logic                   done;
    logic [VALUE_W-1:0]     count_value;
    logic                   active;
    logic                   cfg_we = 1'b0;
    logic [NUM_PATHS_W-1:0] cfg_data = '0;

    trigger_coincidence_counter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .results_valid (results_valid),
        .global_accept (global_accept),
        .fired_paths   (fired_paths),
        .counter_kind  (counter_kind),
        .counter_row   (counter_row),
        .counter_col   (counter_col),
        .done          (done),
        .count_value   (count_value),
        .active        (active),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the counter state, updated on every accepted transfer
    // ------------------------------------------------------------------
    logic [NUM_PATHS_W-1:0] shadow_num_paths;
    logic                   shadow_active;
    logic [VALUE_W-1:0]     shadow_events;
    logic [VALUE_W-1:0]     shadow_accepts;
    logic [VALUE_W-1:0]     shadow_path_hits [PATHS];
    logic [VALUE_W-1:0]     shadow_pair_hits [PATHS][PATHS];

    readout_t expected_readouts[$];
    int       error_count = 0;

    // sender burst shaping
    int burst_left = 0;
    int burst_gap  = 0;

    // counters stick at all ones
    function automatic logic [VALUE_W-1:0] saturating_bump(input logic [VALUE_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void clear_shadow();
        shadow_num_paths = NUM_PATHS_RESET;
        shadow_active    = 1'b1;
        shadow_events    = '0;
        shadow_accepts   = '0;
        for (int i = 0; i < PATHS; i++)
        begin
            shadow_path_hits[i] = '0;
            for (int j = 0; j < PATHS; j++)
                shadow_pair_hits[i][j] = '0;
        end
    endfunction

    // Tally one event into the shadow counters; an invalid event counts once and
    // then freezes the stream for good.
    function automatic void tally_event(input command_t c);
        int                 limit;
        int                 total;
        logic [PATHS-1:0]   counted;
        if (!shadow_active)
            return;
        shadow_events = saturating_bump(shadow_events);
        if (!c.results_valid)
        begin
            shadow_active = 1'b0;
            return;
        end
        if (!c.global_accept)
            return;
        shadow_accepts = saturating_bump(shadow_accepts);
        // num_paths above the array size behaves as the array size
        limit = (shadow_num_paths > PATHS) ? PATHS : shadow_num_paths;
        for (int i = 0; i < PATHS; i++)
            counted[i] = (i < limit) && c.fired[i];
        total = $countones(counted);
        for (int i = 0; i < PATHS; i++)
        begin
            if (!counted[i])
                continue;
            shadow_path_hits[i] = saturating_bump(shadow_path_hits[i]);
            if (total == 1)
                shadow_pair_hits[i][i] = saturating_bump(shadow_pair_hits[i][i]);
            else
                for (int j = 0; j < PATHS; j++)
                    if (j != i && counted[j])
                        shadow_pair_hits[i][j] = saturating_bump(shadow_pair_hits[i][j]);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] counter_lookup(input command_t c);
        case (c.kind)
            KIND_EVENTS:  return shadow_events;
            KIND_ACCEPTS: return shadow_accepts;
            KIND_PATH:    return shadow_path_hits[c.row];
            default:      return shadow_pair_hits[c.row][c.col];
        endcase
    endfunction

    function automatic readout_t predict_readout(input command_t c);
        readout_t r;
        r.count_value = '0;
        if (c.op == MODE_EVENT)
            tally_event(c);
        else
            r.count_value = counter_lookup(c);
        r.active = shadow_active;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && done)
        begin
            if (expected_readouts.size() == 0)
            begin
                $error("unexpected result: count_value %0d, active %0b", count_value, active);
                error_count++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                if (count_value !== want.count_value)
                begin
                    $error("count_value: expected %0d, got %0d", want.count_value, count_value);
                    error_count++;
                end
                if (active !== want.active)
                begin
                    $error("active: expected %0b, got %0b", want.active, active);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drive helpers (all called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------

    // One command transfer. The sender works in bursts; a gap opens most new
    // bursts, so idle stretches land in every phase of the pair-row sweep.
    task automatic send_command(input command_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            burst_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (burst_gap > 0)
            begin
                start = 1'b0;
                repeat (burst_gap) @(negedge clk);
            end
        end
        burst_left--;
        start         = 1'b1;
        mode          = c.op;
        results_valid = c.results_valid;
        global_accept = c.global_accept;
        fired_paths   = c.fired;
        counter_kind  = c.kind;
        counter_row   = c.row;
        counter_col   = c.col;
        do
            @(posedge clk);
        while (busy);
        expected_readouts.push_back(predict_readout(c));
        @(negedge clk);
    endtask

    // Let every outstanding result come back, then idle with start low.
    task automatic wait_idle();
        start = 1'b0;
        while (expected_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_num_paths(input logic [NUM_PATHS_W-1:0] value);
        wait_idle();
        cfg_we   = 1'b1;
        cfg_data = value;
        shadow_num_paths = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic command_t make_event(input logic valid, input logic accept,
                                            input logic [FIRED_W-1:0] fired);
        command_t c;
        c.op            = MODE_EVENT;
        c.results_valid = valid;
        c.global_accept = accept;
        c.fired         = fired;
        // read fields are don't-care on an event, so fill them with noise
        c.kind          = kind_t'(2'($urandom_range(0, 3)));
        c.row           = ROW_W'($urandom_range(0, PATHS - 1));
        c.col           = ROW_W'($urandom_range(0, PATHS - 1));
        return c;
    endfunction

    function automatic command_t make_read(input kind_t kind, input int row, input int col);
        command_t c;
        c.op            = MODE_READ;
        c.kind          = kind;
        c.row           = ROW_W'(row);
        c.col           = ROW_W'(col);
        // event fields are ignored on a read
        c.results_valid = 1'($urandom_range(0, 1));
        c.global_accept = 1'($urandom_range(0, 1));
        c.fired         = FIRED_W'($urandom);
        return c;
    endfunction

    // Mostly sparse masks so that single-path (diagonal) hits are common.
    function automatic logic [FIRED_W-1:0] random_mask();
        int pick;
        logic [FIRED_W-1:0] m;
        pick = $urandom_range(0, 9);
        m = '0;
        if (pick == 0)
            m = '0;
        else if (pick <= 3)
            m[$urandom_range(0, FIRED_W - 1)] = 1'b1;
        else if (pick <= 6)
            repeat ($urandom_range(2, 3)) m[$urandom_range(0, FIRED_W - 1)] = 1'b1;
        else
            m = FIRED_W'($urandom);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All counters start at zero, stream starts active.
    task automatic test_reset_state();
        send_command(make_read(KIND_EVENTS, 0, 0));
        send_command(make_read(KIND_ACCEPTS, 15, 15));
        send_command(make_read(KIND_PATH, 0, 0));
        send_command(make_read(KIND_PATH, 15, 0));
        send_command(make_read(KIND_PAIR, 0, 0));
        send_command(make_read(KIND_PAIR, 15, 0));
    endtask

    // Empty mask, full mask, lone low/high path, rejected event.
    task automatic test_event_extremes();
        send_command(make_event(1'b1, 1'b1, 16'h0000));
        send_command(make_event(1'b1, 1'b1, 16'hFFFF));
        send_command(make_event(1'b1, 1'b1, 16'h0001));
        send_command(make_event(1'b1, 1'b1, 16'h8000));
        send_command(make_event(1'b1, 1'b0, 16'hFFFF));
        send_command(make_read(KIND_PAIR, 0, 15));
        send_command(make_read(KIND_PAIR, 15, 15));
        send_command(make_read(KIND_PAIR, 0, 0));
        send_command(make_read(KIND_PATH, 15, 3));
        send_command(make_read(KIND_ACCEPTS, 0, 0));
        send_command(make_read(KIND_EVENTS, 0, 0));
    endtask

    // num_paths masks upper paths; zero counts no path; above the array size clamps.
    task automatic test_path_limit();
        write_num_paths(NUM_PATHS_W'(1));
        send_command(make_event(1'b1, 1'b1, 16'hFFFF));
        send_command(make_read(KIND_PAIR, 0, 0));
        write_num_paths(NUM_PATHS_W'(0));
        send_command(make_event(1'b1, 1'b1, 16'hFFFF));
        send_command(make_read(KIND_ACCEPTS, 0, 0));
        write_num_paths('1);
        send_command(make_event(1'b1, 1'b1, 16'hFFFF));
        send_command(make_read(KIND_PAIR, 15, 14));
    endtask

    // Bulk traffic over a series of num_paths settings; stream stays valid.
    task automatic test_random_traffic();
        logic [NUM_PATHS_W-1:0] settings [8];
        int row;
        settings = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd8, 5'd0, 5'd16};
        settings[3] = NUM_PATHS_W'($urandom_range(0, 31));
        foreach (settings[p])
        begin
            write_num_paths(settings[p]);
            repeat (65)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    row = $urandom_range(0, PATHS - 1);
                    send_command(make_read(kind_t'(2'($urandom_range(0, 3))), row,
                        ($urandom_range(0, 3) == 0) ? row : $urandom_range(0, PATHS - 1)));
                end
                else
                    send_command(make_event(1'b1, 1'($urandom_range(0, 3) != 0), random_mask()));
            end
        end
    endtask

    // An invalid event is counted and then freezes everything; reads still work.
    task automatic test_stream_stop();
        send_command(make_event(1'b0, 1'b1, 16'hFFFF));
        send_command(make_event(1'b1, 1'b1, 16'hFFFF));
        send_command(make_event(1'b1, 1'b1, 16'h0004));
        send_command(make_event(1'b0, 1'b0, 16'h0000));
        send_command(make_read(KIND_EVENTS, 0, 0));
        send_command(make_read(KIND_ACCEPTS, 0, 0));
        send_command(make_read(KIND_PATH, 2, 0));
        send_command(make_read(KIND_PAIR, 2, 2));
        send_command(make_read(KIND_PAIR, 0, 1));
    endtask

    initial
    begin
        int drain;
        clear_shadow();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_event_extremes();
        test_path_limit();
        test_random_traffic();
        test_stream_stop();

        // drain: the longest wait is for a full sweep, through SWEEP and FLUSH
        start = 1'b0;
        drain = 0;
        while (expected_readouts.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (25) @(posedge clk);
        if (expected_readouts.size() != 0)
        begin
            $error("%0d results never arrived", expected_readouts.size());
            error_count++;
        end

        if (error_count == 0)
            $display("trigger_coincidence_counter_core test passed");
        else
            $display("trigger_coincidence_counter_core test failed");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #10ms;
        $display("trigger_coincidence_counter_core test failed");
        $finish;
    end

endmodule
